// File: hw/rtl/apps_pkg.sv
package apps_pkg;

  // default geometry
  localparam int APPS_NUM_CHANNELS      = 4;
  localparam int APPS_BANKS_PER_CHANNEL = 16;
  localparam int APPS_ROW_BITS          = 16;

  // command codes of a queued request
  localparam logic [2:0] CMD_COLRD = 3'd0;
  localparam logic [2:0] CMD_COLWR = 3'd1;
  localparam logic [2:0] CMD_ACT   = 3'd2;
  localparam logic [2:0] CMD_PRE   = 3'd3;

  localparam logic [3:0] COUNTER_MAX   = 4'd15;
  localparam logic [3:0] COUNTER_RESET = 4'd10;

  // register reset values
  localparam logic [3:0] POL_HI_RESET = 4'd12;
  localparam logic [3:0] POL_LO_RESET = 4'd7;
  localparam logic [5:0] WR_HI_RESET  = 6'd40;
  localparam logic [5:0] WR_LO_RESET  = 6'd20;

  typedef enum logic [1:0] {
    CFG_POL_HI = 2'd0,
    CFG_POL_LO = 2'd1,
    CFG_WR_HI  = 2'd2,
    CFG_WR_LO  = 2'd3
  } apps_cfg_idx_t;

  typedef struct packed {
    logic [3:0] policy_high_threshold;
    logic [3:0] policy_low_threshold;
    logic [5:0] write_high_watermark;
    logic [5:0] write_low_watermark;
  } apps_cfg_t;

  typedef struct packed {
    logic [1:0]  channel_index;
    logic [5:0]  write_queue_count;
    logic [5:0]  read_queue_count;
    logic        write_candidate_valid;
    logic [2:0]  write_candidate_cmd;
    logic [3:0]  write_candidate_bank;
    logic [15:0] write_candidate_row;
    logic        read_candidate_valid;
    logic [2:0]  read_candidate_cmd;
    logic [3:0]  read_candidate_bank;
    logic [15:0] read_candidate_row;
    logic [15:0] precharge_allowed_mask;
  } apps_in_t;

  typedef struct packed {
    logic       issue_request;
    logic       issue_from_writes;
    logic       row_was_hit;
    logic       precharge_issue;
    logic [3:0] precharge_bank_index;
    logic       closed_policy_active;
    logic       draining_writes;
  } apps_out_t;

  // state updates produced by one scheduling decision
  typedef struct packed {
    logic [3:0] ctr;
    logic       closed;
    logic       drain;
    logic       row_we;
    logic       cc_we;
    logic       cc_val;
  } apps_upd_t;

endpackage

// File: hw/rtl/apps_ram.sv
module apps_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                                  clk,
  input  logic                                  wr_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                      wr_data,
  input  logic                                  rd_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                      rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// File: hw/rtl/apps_decide.sv
module apps_decide import apps_pkg::*; #(
  parameter int NUM_CHANNELS      = APPS_NUM_CHANNELS,
  parameter int BANKS_PER_CHANNEL = APPS_BANKS_PER_CHANNEL,
  parameter int ROW_BITS          = APPS_ROW_BITS,
  localparam int NUM_SLOTS = NUM_CHANNELS * BANKS_PER_CHANNEL,
  localparam int SLOT_W    = NUM_SLOTS > 1 ? $clog2(NUM_SLOTS) : 1,
  localparam int CH_W      = NUM_CHANNELS > 1 ? $clog2(NUM_CHANNELS) : 1,
  localparam int RW        = ROW_BITS < 16 ? ROW_BITS : 16
) (
  input  apps_in_t              item,
  input  apps_cfg_t             cfg,
  input  logic [3:0]            ctr,
  input  logic                  closed,
  input  logic                  drain_prev,
  input  logic [CH_W-1:0]       ch,
  input  logic [SLOT_W-1:0]     slot_w,
  input  logic [SLOT_W-1:0]     slot_r,
  input  logic [RW-1:0]         old_row_w,
  input  logic [RW-1:0]         old_row_r,
  input  logic [NUM_SLOTS-1:0]  lrv,
  input  logic [NUM_SLOTS-1:0]  cc,
  output apps_out_t             res,
  output apps_upd_t             upd,
  output logic [SLOT_W-1:0]     slot_sel,
  output logic [RW-1:0]         row_sel,
  output logic [SLOT_W-1:0]     cc_slot
);

  localparam int PRE_N = BANKS_PER_CHANNEL < 16 ? BANKS_PER_CHANNEL : 16;

  logic              drain, closed_n, valid, is_col, hit, pre;
  logic [2:0]        cmd;
  logic [RW-1:0]     old_row;
  logic [3:0]        pbank;
  logic [SLOT_W-1:0] base, pslot;

  always_comb begin
    drain = (drain_prev && (item.write_queue_count > cfg.write_low_watermark)) ||
            (item.write_queue_count > cfg.write_high_watermark) ||
            (item.read_queue_count == 6'd0);

    closed_n = closed;
    if (!closed && (ctr > cfg.policy_high_threshold)) begin
      closed_n = 1'b1;
    end else if (closed && (ctr < cfg.policy_low_threshold)) begin
      closed_n = 1'b0;
    end

    if (drain) begin
      valid    = item.write_candidate_valid;
      cmd      = item.write_candidate_cmd;
      slot_sel = slot_w;
      row_sel  = item.write_candidate_row[RW-1:0];
      old_row  = old_row_w;
      is_col   = item.write_candidate_valid && (item.write_candidate_cmd == CMD_COLWR);
    end else begin
      valid    = item.read_candidate_valid;
      cmd      = item.read_candidate_cmd;
      slot_sel = slot_r;
      row_sel  = item.read_candidate_row[RW-1:0];
      old_row  = old_row_r;
      is_col   = item.read_candidate_valid && (item.read_candidate_cmd == CMD_COLRD);
    end

    hit = is_col && lrv[slot_sel] && (old_row == row_sel);

    // lowest closable bank of this channel that timing lets us precharge
    base  = SLOT_W'(32'(ch) * BANKS_PER_CHANNEL);
    pre   = 1'b0;
    pbank = 4'd0;
    pslot = base;
    for (int b = PRE_N - 1; b >= 0; b--) begin
      if (cc[base + SLOT_W'(b)] && item.precharge_allowed_mask[b]) begin
        pre   = 1'b1;
        pbank = 4'(b);
        pslot = base + SLOT_W'(b);
      end
    end
    pre = pre && closed_n && !valid;
    if (!pre) begin
      pbank = 4'd0;
    end

    upd.ctr = ctr;
    if (is_col) begin
      if (closed_n) begin
        if (hit && (ctr != 4'd0)) upd.ctr = ctr - 4'd1;
      end else if (!hit && (ctr != COUNTER_MAX)) begin
        upd.ctr = ctr + 4'd1;
      end
    end
    upd.closed = closed_n;
    upd.drain  = drain;
    upd.row_we = is_col;

    upd.cc_we  = 1'b0;
    upd.cc_val = 1'b0;
    cc_slot    = slot_sel;
    if (closed_n && is_col) begin
      upd.cc_we  = 1'b1;
      upd.cc_val = 1'b1;
    end else if (closed_n && valid && (cmd inside {CMD_ACT, CMD_PRE})) begin
      upd.cc_we = 1'b1;
    end else if (pre) begin
      upd.cc_we = 1'b1;
      cc_slot   = pslot;
    end

    res.issue_request        = valid;
    res.issue_from_writes    = valid && drain;
    res.row_was_hit          = hit;
    res.precharge_issue      = pre;
    res.precharge_bank_index = pbank;
    res.closed_policy_active = closed_n;
    res.draining_writes      = drain;
  end

endmodule

// File: hw/rtl/adaptive_page_policy_scheduler_core.sv
// Channel   | Handshake           | Payload              | Moves
// ----------+---------------------+----------------------+---------------------------------
// in        | in_valid/in_ready   | in_data  (apps_in_t)  | one scheduling request per beat
// out       | out_valid/out_ready | out_data (apps_out_t) | one decision per request
// cfg       | cfg_we              | cfg_index, cfg_wdata | threshold/watermark writes
//
// One request per clock sustained while out_ready is high. A request waits in the input register,
// where the last-row RAM read for both candidate banks lands, and then the decision is
// written to the output register.
// Synchronous active-low reset sets the policy counter to COUNTER_RESET and clears drain flags,
// row valid bits and close candidates; the last-row RAM needs no clearing pass (valid bits gate it).
// A stalled output holds the decision; the input register still fills behind it.
module adaptive_page_policy_scheduler_core import apps_pkg::*; #(
  parameter int NUM_CHANNELS      = APPS_NUM_CHANNELS,
  parameter int BANKS_PER_CHANNEL = APPS_BANKS_PER_CHANNEL,
  parameter int ROW_BITS          = APPS_ROW_BITS
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  apps_in_t   in_data,
  output logic       out_valid,
  input  logic       out_ready,
  output apps_out_t  out_data,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [5:0] cfg_wdata
);

  localparam int NUM_SLOTS = NUM_CHANNELS * BANKS_PER_CHANNEL;
  localparam int SLOT_W    = NUM_SLOTS > 1 ? $clog2(NUM_SLOTS) : 1;
  localparam int CH_W      = NUM_CHANNELS > 1 ? $clog2(NUM_CHANNELS) : 1;
  localparam int BANK_W    = BANKS_PER_CHANNEL > 1 ? $clog2(BANKS_PER_CHANNEL) : 1;
  localparam int RW        = ROW_BITS < 16 ? ROW_BITS : 16;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  apps_cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.policy_high_threshold <= POL_HI_RESET;
      cfg_r.policy_low_threshold  <= POL_LO_RESET;
      cfg_r.write_high_watermark  <= WR_HI_RESET;
      cfg_r.write_low_watermark   <= WR_LO_RESET;
    end else if (cfg_we) begin
      case (apps_cfg_idx_t'(cfg_index))
        CFG_POL_HI: cfg_r.policy_high_threshold <= cfg_wdata[3:0];
        CFG_POL_LO: cfg_r.policy_low_threshold  <= cfg_wdata[3:0];
        CFG_WR_HI:  cfg_r.write_high_watermark  <= cfg_wdata;
        CFG_WR_LO:  cfg_r.write_low_watermark   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Index folding: channel mod NUM_CHANNELS, bank mod BANKS_PER_CHANNEL.
  // Both are constant lookup tables over the narrow input fields.
  // ---------------------------------------------------------------------------
  logic [CH_W-1:0]   ch_tbl   [4];
  logic [BANK_W-1:0] bank_tbl [16];

  for (genvar gi = 0; gi < 4; gi++) begin : g_ch_tbl
    assign ch_tbl[gi] = CH_W'(gi % NUM_CHANNELS);
  end
  for (genvar gi = 0; gi < 16; gi++) begin : g_bank_tbl
    assign bank_tbl[gi] = BANK_W'(gi % BANKS_PER_CHANNEL);
  end

  logic [CH_W-1:0]   acc_ch;
  logic [SLOT_W-1:0] acc_slot_w, acc_slot_r;

  assign acc_ch     = ch_tbl[in_data.channel_index];
  assign acc_slot_w = SLOT_W'(32'(acc_ch) * BANKS_PER_CHANNEL +
                              32'(bank_tbl[in_data.write_candidate_bank]));
  assign acc_slot_r = SLOT_W'(32'(acc_ch) * BANKS_PER_CHANNEL +
                              32'(bank_tbl[in_data.read_candidate_bank]));

  // ---------------------------------------------------------------------------
  // Pipeline control: input register (s1) -> output register
  // ---------------------------------------------------------------------------
  logic s1_valid_r, s1_valid_nxt;
  logic out_valid_r, out_valid_nxt;
  logic accept, move;

  assign move     = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || move;
  assign accept   = in_valid && in_ready;

  always_comb begin
    s1_valid_nxt  = accept ? 1'b1 : (move ? 1'b0 : s1_valid_r);
    out_valid_nxt = move ? 1'b1 : ((out_valid_r && out_ready) ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // input register payload
  apps_in_t          s1_item_r;
  logic [CH_W-1:0]   s1_ch_r;
  logic [SLOT_W-1:0] s1_slot_w_r, s1_slot_r_r;

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_item_r   <= in_data;
      s1_ch_r     <= acc_ch;
      s1_slot_w_r <= acc_slot_w;
      s1_slot_r_r <= acc_slot_r;
    end
  end

  // ---------------------------------------------------------------------------
  // Scheduler state
  // ---------------------------------------------------------------------------
  logic [3:0]           ctr_r;
  logic                 closed_r;
  logic                 drain_flag_r [NUM_CHANNELS];
  logic [NUM_SLOTS-1:0] lrv_r;
  logic [NUM_SLOTS-1:0] cc_r;

  apps_out_t         res;
  apps_upd_t         upd;
  logic [SLOT_W-1:0] slot_sel, cc_slot;
  logic [RW-1:0]     row_sel;
  logic [RW-1:0]     ram_w_q, ram_r_q;
  logic [RW-1:0]     old_row_w, old_row_r;
  logic              row_wr;

  assign row_wr = move && upd.row_we;

  // Last opened row per bank slot, one copy per candidate so both banks are
  // read at accept time. Both copies see every write.
  apps_ram #(.WIDTH(RW), .DEPTH(NUM_SLOTS)) u_row_w (
    .clk     (clk),
    .wr_en   (row_wr),
    .wr_addr (slot_sel),
    .wr_data (row_sel),
    .rd_en   (accept),
    .rd_addr (acc_slot_w),
    .rd_data (ram_w_q)
  );

  apps_ram #(.WIDTH(RW), .DEPTH(NUM_SLOTS)) u_row_r (
    .clk     (clk),
    .wr_en   (row_wr),
    .wr_addr (slot_sel),
    .wr_data (row_sel),
    .rd_en   (accept),
    .rd_addr (acc_slot_r),
    .rd_data (ram_r_q)
  );

  // Bypass: the request leaving s1 may write the slot the incoming request reads
  // in the same cycle; the RAM returns old data then, so capture the new row.
  logic          fwd_w_r, fwd_r_r;
  logic [RW-1:0] fwd_row_r;

  always_ff @(posedge clk) begin
    if (accept) begin
      fwd_w_r   <= row_wr && (slot_sel == acc_slot_w);
      fwd_r_r   <= row_wr && (slot_sel == acc_slot_r);
      fwd_row_r <= row_sel;
    end
  end

  assign old_row_w = fwd_w_r ? fwd_row_r : ram_w_q;
  assign old_row_r = fwd_r_r ? fwd_row_r : ram_r_q;

  apps_decide #(
    .NUM_CHANNELS      (NUM_CHANNELS),
    .BANKS_PER_CHANNEL (BANKS_PER_CHANNEL),
    .ROW_BITS          (ROW_BITS)
  ) u_decide (
    .item       (s1_item_r),
    .cfg        (cfg_r),
    .ctr        (ctr_r),
    .closed     (closed_r),
    .drain_prev (drain_flag_r[s1_ch_r]),
    .ch         (s1_ch_r),
    .slot_w     (s1_slot_w_r),
    .slot_r     (s1_slot_r_r),
    .old_row_w  (old_row_w),
    .old_row_r  (old_row_r),
    .lrv        (lrv_r),
    .cc         (cc_r),
    .res        (res),
    .upd        (upd),
    .slot_sel   (slot_sel),
    .row_sel    (row_sel),
    .cc_slot    (cc_slot)
  );

  // state commits when the decision moves to the output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctr_r    <= COUNTER_RESET;
      closed_r <= 1'b0;
      lrv_r    <= '0;
      cc_r     <= '0;
      for (int c = 0; c < NUM_CHANNELS; c++) begin
        drain_flag_r[c] <= 1'b0;
      end
    end else if (move) begin
      ctr_r                 <= upd.ctr;
      closed_r              <= upd.closed;
      drain_flag_r[s1_ch_r] <= upd.drain;
      if (upd.row_we) begin
        lrv_r[slot_sel] <= 1'b1;
      end
      if (upd.cc_we) begin
        cc_r[cc_slot] <= upd.cc_val;
      end
    end
  end

  // output register
  apps_out_t out_data_r;

  always_ff @(posedge clk) begin
    if (move) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// File: hw/rtl/apps_checker.sv
module apps_checker import apps_pkg::*; (
  input logic       clk,
  input logic       rst_n,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input apps_out_t  out_data
);

  // reset empties both stages
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> (!out_valid && in_ready))
    else $error("pipeline not empty after reset");

  // input only back-pressures when the output is full and stalled
  a_no_false_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (out_valid && !out_ready))
    else $error("input stalled while output can drain");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_data)))
    else $error("stalled decision changed");

  a_pre_excl: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.precharge_issue) |->
      (!out_data.issue_request && out_data.closed_policy_active))
    else $error("aggressive precharge with issue or in open mode");

  a_wr_issue: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.issue_from_writes) |->
      (out_data.issue_request && out_data.draining_writes))
    else $error("write issue outside drain mode");

endmodule

bind adaptive_page_policy_scheduler_core apps_checker u_apps_checker (.*);
